@@ sv/bitmap_frame_allocator_top_defines.svh @@
// Assertion macros used by the frame allocator controller
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst_n is low
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bfa_pkg.sv @@
// Shared types and constants of the bitmap frame allocator
`default_nettype none

package bfa_pkg;

    localparam int FRAME_SHIFT = 12;
    localparam int FRAME_W     = 22;
    localparam int OUT_CNT_W   = 17;
    localparam int RSV_FRAMES  = 12288;

    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_ALLOC   = 3'd1;
    localparam logic [2:0] MODE_FREE    = 3'd2;
    localparam logic [2:0] MODE_RESERVE = 3'd3;
    localparam logic [2:0] MODE_RELEASE = 3'd4;

    typedef struct packed {
        logic load_op;
        logic prep;
        logic init_wr;
        logic rd;
        logic scan_chk;
        logic reg_wr;
        logic ptr_inc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic op_init;
        logic op_alloc;
        logic op_region;
        logic region_empty;
        logic total_zero;
        logic ptr_last;
        logic found;
    } status_t;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            n = n + 6'(v[i]);
        end
        return n;
    endfunction

    // lowest clear bit position of a word
    function automatic logic [4:0] low_zero32(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 31; i >= 0; i--) begin
            if (!v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ sv/bfa_ram.sv @@
// Generic simple dual-port RAM with registered read
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/bfa_datapath.sv @@
// Datapath: bitmap RAM, counters, region bounds and result registers
`default_nettype none

module bfa_datapath
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic                 cfg_valid,
    input  wire logic [31:0]          cfg_data,
    input  wire logic [2:0]           mode,
    input  wire logic [31:0]          address,
    input  wire logic [31:0]          length,
    output logic [31:0]               alloc_address,
    output logic [OUT_CNT_W-1:0]      free_blocks,
    output logic [OUT_CNT_W-1:0]      total_blocks
);
    localparam int WORDS = (MAX_FRAMES + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(MAX_FRAMES + 1);

    logic [2:0]           mode_reg;
    logic [31:0]          addr_reg;
    logic [31:0]          len_reg;
    logic [31:0]          mem_kb_reg;
    logic [CW-1:0]        total_reg, total_next;
    logic [CW-1:0]        used_reg, used_next;
    logic [FRAME_W-1:0]   first_reg, first_next;
    logic [FRAME_W-1:0]   last_reg, last_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        end_reg, end_next;
    logic [31:0]          alloc_reg, alloc_next;
    logic [31:0]          alloc_out_reg;
    logic [OUT_CNT_W-1:0] free_out_reg;
    logic [OUT_CNT_W-1:0] total_out_reg;

    logic                 ram_we;
    logic [31:0]          ram_wdata;
    logic [31:0]          ram_rdata;

    logic [FRAME_W-1:0]   total_ext;
    logic [FRAME_W-1:0]   p_first, p_last;
    logic [33:0]          sum_res, sum_rel_lo, sum_rel_hi;
    logic [FRAME_W-1:0]   last_m1;
    logic [FRAME_W-1:0]   total_m1;
    logic [29:0]          kb_frames;
    logic [CW-1:0]        init_total;
    logic [31:0]          init_word;
    logic [31:0]          beyond_mask;
    logic [31:0]          scan_eff;
    logic [4:0]           zero_pos;
    logic [31:0]          reg_mask;
    logic [4:0]           lo_bit, hi_bit;
    logic [31:0]          reg_word;
    logic [5:0]           reg_delta;
    logic                 is_set;

    function automatic logic [FRAME_W-1:0] clamp(input logic [FRAME_W-1:0] v,
                                                  input logic [FRAME_W-1:0] t);
        return (v > t) ? t : v;
    endfunction

    assign total_ext = FRAME_W'(total_reg);
    assign total_m1  = total_ext - FRAME_W'(1);
    assign last_m1   = last_reg - FRAME_W'(1);
    assign is_set    = (mode_reg == MODE_RESERVE);

    // region bounds of the latched operation
    assign sum_res    = 34'(addr_reg) + 34'(len_reg) + 34'(4095);
    assign sum_rel_lo = 34'(addr_reg) + 34'(4095);
    assign sum_rel_hi = 34'(addr_reg) + 34'(len_reg);

    always_comb
    begin
        p_first = '0;
        p_last  = '0;
        case (mode_reg)
            MODE_FREE: begin
                p_first = FRAME_W'(addr_reg[31:FRAME_SHIFT]);
                p_last  = clamp(p_first + FRAME_W'(1), total_ext);
            end
            MODE_RESERVE: begin
                p_first = FRAME_W'(addr_reg[31:FRAME_SHIFT]);
                p_last  = clamp(sum_res[33:FRAME_SHIFT], total_ext);
            end
            MODE_RELEASE: begin
                p_first = clamp(FRAME_W'(sum_rel_lo[33:FRAME_SHIFT]), total_ext);
                p_last  = clamp(sum_rel_hi[33:FRAME_SHIFT], total_ext);
            end
            default: begin
                p_first = '0;
                p_last  = '0;
            end
        endcase
    end

    // frame total from installed memory
    assign kb_frames  = mem_kb_reg[31:2];
    assign init_total = (kb_frames > 30'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(kb_frames);

    // init word: low reserve and frames past the end are used
    always_comb
    begin
        for (int b = 0; b < 32; b++) begin
            init_word[b] = (FRAME_W'({ptr_reg, 5'(b)}) < FRAME_W'(RSV_FRAMES)) ||
                           (FRAME_W'({ptr_reg, 5'(b)}) >= total_ext);
            beyond_mask[b] = (FRAME_W'({ptr_reg, 5'(b)}) >= total_ext);
        end
    end

    // first-fit search within the word just read
    assign scan_eff = ram_rdata | beyond_mask;
    assign zero_pos = low_zero32(scan_eff);

    // region mask and update of the word just read
    assign lo_bit    = (ptr_reg == first_reg[AW+4:5]) ? first_reg[4:0] : 5'd0;
    assign hi_bit    = (ptr_reg == end_reg) ? last_m1[4:0] : 5'd31;
    assign reg_mask  = ({32{1'b1}} << lo_bit) & ({32{1'b1}} >> (5'd31 - hi_bit));
    assign reg_word  = is_set ? (ram_rdata | reg_mask) : (ram_rdata & ~reg_mask);
    assign reg_delta = is_set ? popcount32(reg_mask & ~ram_rdata)
                              : popcount32(reg_mask & ram_rdata);

    // select the RAM write
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = init_word;
        if (cmd.init_wr) begin
            ram_we    = 1'b1;
            ram_wdata = init_word;
        end else if (cmd.scan_chk && (scan_eff != '1)) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (32'd1 << zero_pos);
        end else if (cmd.reg_wr) begin
            ram_we    = 1'b1;
            ram_wdata = reg_word;
        end
    end

    // next state of counters, bounds and pointer
    always_comb
    begin
        total_next = total_reg;
        used_next  = used_reg;
        first_next = first_reg;
        last_next  = last_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        alloc_next = alloc_reg;
        if (cmd.load_op) begin
            alloc_next = '0;
        end
        if (cmd.prep) begin
            first_next = p_first;
            last_next  = p_last;
            ptr_next   = '0;
            end_next   = AW'(WORDS - 1);
            if (mode_reg == MODE_INIT) begin
                total_next = init_total;
                used_next  = (FRAME_W'(init_total) > FRAME_W'(RSV_FRAMES)) ? CW'(RSV_FRAMES)
                                                                           : init_total;
            end else if (mode_reg == MODE_ALLOC) begin
                end_next = total_m1[AW+4:5];
            end else begin
                ptr_next = p_first[AW+4:5];
                end_next = FRAME_W'(p_last - FRAME_W'(1)) >> 5 == '0 ? '0
                         : AW'(FRAME_W'(p_last - FRAME_W'(1)) >> 5);
            end
        end
        if (cmd.scan_chk && (scan_eff != '1)) begin
            used_next  = used_reg + CW'(1);
            alloc_next = 32'({ptr_reg, zero_pos}) << FRAME_SHIFT;
        end
        if (cmd.reg_wr) begin
            used_next = is_set ? used_reg + CW'(reg_delta) : used_reg - CW'(reg_delta);
        end
        if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + AW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mem_kb_reg <= '0;
            total_reg  <= '0;
            used_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                mem_kb_reg <= cfg_data;
            end
            total_reg <= total_next;
            used_reg  <= used_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_op) begin
            mode_reg <= mode;
            addr_reg <= address;
            len_reg  <= length;
        end
        first_reg <= first_next;
        last_reg  <= last_next;
        ptr_reg   <= ptr_next;
        end_reg   <= end_next;
        alloc_reg <= alloc_next;
        if (cmd.out_load) begin
            alloc_out_reg <= alloc_reg;
            free_out_reg  <= OUT_CNT_W'(total_reg - used_reg);
            total_out_reg <= OUT_CNT_W'(total_reg);
        end
    end

    bfa_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // status back to the controller
    assign status.op_init      = (mode_reg == MODE_INIT);
    assign status.op_alloc     = (mode_reg == MODE_ALLOC);
    assign status.op_region    = (mode_reg == MODE_FREE) || (mode_reg == MODE_RESERVE) ||
                                 (mode_reg == MODE_RELEASE);
    assign status.region_empty = ((mode_reg == MODE_FREE) && (addr_reg[FRAME_SHIFT-1:0] != '0))
                                 || !(p_first < p_last);
    assign status.total_zero   = (total_reg == '0);
    assign status.ptr_last     = (ptr_reg == end_reg);
    assign status.found        = (scan_eff != '1);

    assign alloc_address = alloc_out_reg;
    assign free_blocks   = free_out_reg;
    assign total_blocks  = total_out_reg;

endmodule

`default_nettype wire

@@ sv/bfa_ctrl.sv @@
// Controller state machine of the frame allocator
`default_nettype none

module bfa_ctrl
    import bfa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);
`include "bitmap_frame_allocator_top_defines.svh"

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PREP     = 8'b0000_0010,
        S_INIT     = 8'b0000_0100,
        S_SCAN_RD  = 8'b0000_1000,
        S_SCAN_CHK = 8'b0001_0000,
        S_REG_RD   = 8'b0010_0000,
        S_REG_WR   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // sequence one operation
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_op = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                if (status.op_init) begin
                    state_next = S_INIT;
                end else if (status.op_alloc) begin
                    state_next = status.total_zero ? S_DONE : S_SCAN_RD;
                end else if (status.op_region) begin
                    state_next = status.region_empty ? S_DONE : S_REG_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_INIT: begin
                cmd.init_wr = 1'b1;
                if (status.ptr_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_SCAN_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                cmd.scan_chk = 1'b1;
                if (status.found || status.ptr_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_REG_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_REG_WR;
            end
            S_REG_WR: begin
                cmd.reg_wr = 1'b1;
                if (status.ptr_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_REG_RD;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold the result until the downstream transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `BFA_ASSERT_NEXT(a_accept_preps, in_valid && in_ready, state_reg == S_PREP,
                     "accepted transaction did not start preparation")
    `BFA_ASSERT_NEXT(a_done_publishes, (state_reg == S_DONE) && slot_free,
                     out_valid_reg && (state_reg == S_IDLE),
                     "finished operation did not publish its result")
    `BFA_ASSERT_NEXT(a_init_ends, (state_reg == S_INIT) && status.ptr_last,
                     state_reg == S_DONE, "init sweep ran past its last word")

endmodule

`default_nettype wire

@@ sv/bitmap_frame_allocator_top.sv @@
// Init writes one bitmap word per cycle, sweeping every word of the bitmap.
// Allocate reads and checks each bitmap word in turn up to the first free frame.
// Free and region operations read and rewrite each bitmap word in the region.
// One transaction is processed at a time; the bitmap RAM read-modify-write sets the pace.
// Reset clears counters, frame total and memory size; the bitmap holds no
// meaning until the first init, which rewrites every word.
`default_nettype none

module bitmap_frame_allocator_top
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           mode,
    input  wire logic [31:0]          address,
    input  wire logic [31:0]          length,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [31:0]               alloc_address,
    output logic [OUT_CNT_W-1:0]      free_blocks,
    output logic [OUT_CNT_W-1:0]      total_blocks
);
    cmd_t    cmd;
    status_t status;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bfa_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .address       (address),
        .length        (length),
        .alloc_address (alloc_address),
        .free_blocks   (free_blocks),
        .total_blocks  (total_blocks)
    );

endmodule

`default_nettype wire
